>>> rtl/rcgba_pkg.sv
// ============================================================================
// rcgba_pkg: shared constants for the RGB565 crop, gray and block average
// Frame geometry, tile sizing and the reciprocal used for normalisation.
// ============================================================================
package rcgba_pkg;

	// Frame and output grid geometry.
	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;
	localparam int CROP_SIDE    = 240;
	localparam int OUT_WIDTH    = 48;
	localparam int OUT_HEIGHT   = 48;

	// Tile edge in pixels, never below one.
	localparam int BLOCK   = (CROP_SIDE / OUT_WIDTH) < 1 ? 1 : (CROP_SIDE / OUT_WIDTH);
	localparam int CROP_X0 = (FRAME_WIDTH - CROP_SIDE) / 2;
	localparam int CROP_Y0 = (FRAME_HEIGHT - CROP_SIDE) / 2;
	localparam int CROP_X1 = CROP_X0 + OUT_WIDTH * BLOCK;
	localparam int CROP_Y1 = CROP_Y0 + OUT_HEIGHT * BLOCK;

	// Counter and index widths.
	localparam int COL_W   = $clog2(FRAME_WIDTH);
	localparam int ROW_W   = $clog2(FRAME_HEIGHT);
	localparam int DX_W    = $clog2(BLOCK + 1);
	localparam int TX_W    = $clog2(OUT_WIDTH + 1);
	localparam int TY_W    = $clog2(OUT_HEIGHT + 1);
	localparam int ADDR_W  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;

	// Tile sum width and the divisor of the normalisation.
	localparam int DEN     = BLOCK * BLOCK * 255;
	localparam int SUM_W   = $clog2(DEN + 1);
	localparam int DEN_LOG = $clog2(DEN);

	// floor(sum * 2^15 / DEN) equals (sum * RECIP_M) >> RECIP_SHIFT for every
	// sum below 2^SUM_W, with RECIP_M rounded up.
	localparam int RECIP_SHIFT = SUM_W + DEN_LOG;
	localparam longint unsigned RECIP_M =
		((64'd1 << (RECIP_SHIFT + 15)) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int RECIP_W = $clog2(RECIP_M + 64'd1);
	localparam int PROD_W  = SUM_W + RECIP_W;

	// Port field widths.
	localparam int PIXEL_W   = 16;
	localparam int FEATURE_W = 16;
	localparam int COORD_W   = 6;
	localparam int OUT_DATA_W = 32;

	// Full scale of the Q1.15 feature.
	localparam logic [FEATURE_W-1:0] FEATURE_ONE = 16'h8000;

	typedef logic [COORD_W-1:0] coord_t;

endpackage

>>> rtl/rcgba_ram.sv
// ============================================================================
// rcgba_ram: generic single-write, single-read RAM with registered read
// Read data changes only on a cycle with the read enable high.
// ============================================================================
module rcgba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/rgb565_crop_gray_block_average.sv
// ============================================================================
// rgb565_crop_gray_block_average: camera crop, gray conversion, tile average
// Streams RGB565 pixels in, streams one normalised gray feature per tile out.
// ============================================================================
// Usage
// The slave channel takes one RGB565 pixel per transaction in raster order;
// s_tuser marks the top-left pixel of a frame and restarts the position
// counters. Pixels outside the centred square crop are consumed and dropped.
// Each kept pixel's gray value is added into a per-column tile accumulator
// held in a small RAM; when a tile's bottom-right pixel arrives, the master
// channel carries one transaction with the tile mean in Q1.15 (32768 = 1.0),
// the tile coordinates, and tlast on the final tile of the frame.
// Throughput is one pixel per clock while s_tready is high. A feature
// passes the accumulate stage with its RAM read-back, which is loaded on
// the edge that accepts its closing pixel, then the reciprocal multiply
// and the output register.
// Reset clears the position counters and all valid flags; the accumulator
// RAM needs no clearing, as the first pixel of each tile loads it.
// When the receiver stalls, the output register holds its feature; pixels
// that close no tile keep flowing, and input is held off only once a
// further finished feature has nowhere to go.
// ============================================================================
module rgb565_crop_gray_block_average
	import rcgba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel input channel.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_W-1:0]    s_tdata,   // [15:0] pixel
	input  logic [0:0]            s_tuser,   // [0] frame_start
	// Feature output channel.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] feature, [21:16] tile_x,
	                                         // [27:22] tile_y, [31:28] zero
	output logic                  m_tlast    // frame_last
);

	// ------------------------------------------------------------------
	// Position state, describing the next pixel to arrive.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DX_W-1:0]  dx_q, dy_q;
	logic [TX_W-1:0]  tx_q;
	logic [TY_W-1:0]  ty_q;

	// Effective position of the incoming pixel; a frame start forces zero.
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic [DX_W-1:0]  dx_e, dy_e;
	logic [TX_W-1:0]  tx_e;
	logic [TY_W-1:0]  ty_e;

	logic             accept;
	logic             in_win, col_in, row_in, dx_last, dy_last, col_last, row_last;
	logic [4:0]       r5, b5;
	logic [5:0]       g6;
	logic [7:0]       r8, g8, b8, gray;
	logic [11:0]      gray_wsum;

	// Stage 1: accumulate.
	logic              valid_s1, win_s1, load_s1, emit_s1, last_s1, fwd_s1;
	logic [7:0]        gray_s1;
	logic [ADDR_W-1:0] addr_s1;
	coord_t            tx_s1, ty_s1;
	logic [SUM_W-1:0]  fwd_data_s1;
	logic [SUM_W-1:0]  rd_data, base_s1, sum_s1;
	logic              adv_s1, wr_en;

	// Stage 2: normalise.
	logic              valid_s2, last_s2, adv_s2;
	logic [SUM_W-1:0]  sum_s2;
	coord_t            tx_s2, ty_s2;
	logic [PROD_W-1:0] prod_s2;

	// Output register.
	logic                 out_valid_q, out_last_q;
	logic [FEATURE_W-1:0] feature_q;
	coord_t               out_tx_q, out_ty_q;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		if (s_tuser[0]) begin
			col_e = '0;
			row_e = '0;
			dx_e  = '0;
			dy_e  = '0;
			tx_e  = '0;
			ty_e  = '0;
		end else begin
			col_e = col_q;
			row_e = row_q;
			dx_e  = dx_q;
			dy_e  = dy_q;
			tx_e  = tx_q;
			ty_e  = ty_q;
		end
	end

	assign col_in   = (int'(col_e) >= CROP_X0) && (int'(col_e) < CROP_X1);
	assign row_in   = (int'(row_e) >= CROP_Y0) && (int'(row_e) < CROP_Y1);
	assign in_win   = col_in && row_in;
	assign dx_last  = (dx_e == DX_W'(BLOCK - 1));
	assign dy_last  = (dy_e == DX_W'(BLOCK - 1));
	assign col_last = (col_e == COL_W'(FRAME_WIDTH - 1));
	assign row_last = (row_e == ROW_W'(FRAME_HEIGHT - 1));

	// Gray conversion: widen by bit replication, then (5r + 9g + 2b) >> 4.
	assign r5 = s_tdata[15:11];
	assign g6 = s_tdata[10:5];
	assign b5 = s_tdata[4:0];
	assign r8 = {r5, r5[4:2]};
	assign g8 = {g6, g6[5:4]};
	assign b8 = {b5, b5[4:2]};
	assign gray_wsum = 12'(r8) * 12'd5 + 12'(g8) * 12'd9 + 12'(b8) * 12'd2;
	assign gray      = gray_wsum[11:4];

	// Position counters. Tile counters advance only once the crop has started
	// on that axis; beyond the crop their values are never used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			tx_q  <= '0;
			ty_q  <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				dx_q  <= '0;
				tx_q  <= '0;
				if (row_last) begin
					row_q <= '0;
					dy_q  <= '0;
					ty_q  <= '0;
				end else begin
					row_q <= row_e + ROW_W'(1);
					if (int'(row_e) >= CROP_Y0) begin
						dy_q <= dy_last ? '0 : dy_e + DX_W'(1);
						ty_q <= dy_last ? ty_e + TY_W'(1) : ty_e;
					end else begin
						dy_q <= '0;
						ty_q <= '0;
					end
				end
			end else begin
				col_q <= col_e + COL_W'(1);
				row_q <= row_e;
				dy_q  <= dy_e;
				ty_q  <= ty_e;
				if (int'(col_e) >= CROP_X0) begin
					dx_q <= dx_last ? '0 : dx_e + DX_W'(1);
					tx_q <= dx_last ? tx_e + TX_W'(1) : tx_e;
				end else begin
					dx_q <= '0;
					tx_q <= '0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: read-modify-write of the column accumulator. The RAM is read
	// on the accepting edge; a write to the same entry on that very edge is
	// forwarded, as the RAM would return the old contents.
	// ------------------------------------------------------------------
	assign adv_s1   = valid_s1 && (!emit_s1 || !valid_s2 || adv_s2);
	assign s_tready = !valid_s1 || adv_s1;
	assign wr_en    = adv_s1 && win_s1;
	assign base_s1  = fwd_s1 ? fwd_data_s1 : rd_data;
	assign sum_s1   = load_s1 ? SUM_W'(gray_s1) : base_s1 + SUM_W'(gray_s1);

	rcgba_ram #(
		.WIDTH(SUM_W),
		.DEPTH(OUT_WIDTH)
	) u_tile_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (sum_s1),
		.rd_en   (accept),
		.rd_addr (tx_e[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1      <= in_win;
			load_s1     <= (dx_e == '0) && (dy_e == '0);
			emit_s1     <= in_win && dx_last && dy_last;
			last_s1     <= (tx_e == TX_W'(OUT_WIDTH - 1)) && (ty_e == TY_W'(OUT_HEIGHT - 1));
			gray_s1     <= gray;
			addr_s1     <= tx_e[ADDR_W-1:0];
			tx_s1       <= COORD_W'(tx_e);
			ty_s1       <= COORD_W'(ty_e);
			fwd_s1      <= wr_en && (addr_s1 == tx_e[ADDR_W-1:0]);
			fwd_data_s1 <= sum_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: normalise the tile sum by a reciprocal multiply.
	// ------------------------------------------------------------------
	assign adv_s2  = valid_s2 && (!out_valid_q || m_tready);
	assign prod_s2 = PROD_W'(sum_s2) * PROD_W'(RECIP_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv_s2) begin
			valid_s2 <= adv_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			sum_s2  <= sum_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			feature_q  <= FEATURE_W'(prod_s2 >> RECIP_SHIFT);
			out_tx_q   <= tx_s2;
			out_ty_q   <= ty_s2;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_ty_q, out_tx_q, feature_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/rcgba_checker.sv
// ============================================================================
// rcgba_checker: port-level assertions for the crop, gray and tile averager
// Watches the feature channel and is bound to the top level.
// ============================================================================
module rcgba_checker
	import rcgba_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [PIXEL_W-1:0]    s_tdata,
	input logic [0:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	logic [FEATURE_W-1:0] feature;
	coord_t               tile_x, tile_y;
	logic                 in_seen;

	assign feature = m_tdata[15:0];
	assign tile_x  = m_tdata[21:16];
	assign tile_y  = m_tdata[27:22];
	assign in_seen = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

	// A stalled feature stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("feature changed while stalled");

	// The tile mean never exceeds full scale.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> feature <= FEATURE_ONE)
		else $error("feature above 1.0");

	// The frame's last tile is exactly the bottom-right one.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == ((tile_x == COORD_W'(OUT_WIDTH - 1)) &&
		                         (tile_y == COORD_W'(OUT_HEIGHT - 1)))))
		else $error("tlast does not match the last tile");

	// A new feature appears only after a pixel has been taken earlier.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_seen, 3) || $past(in_seen, 4) || $past(m_tvalid))
		else $error("feature without a closing pixel");

endmodule

bind rgb565_crop_gray_block_average rcgba_checker u_rcgba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> bench/tb.sv
// ============================================================================
// tb: testbench for rgb565_crop_gray_block_average
// Drives RGB565 camera pixels through the slave channel with random bursts
// and gaps, predicts every tile feature from the frame position, the crop and
// the per-column tile sums, and checks each master transaction in order while
// the receiver stalls on a pattern of its own.
// ============================================================================
module tb;
	import rcgba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One expected tile feature, with the fields as they travel on the master side.
	typedef struct packed {
		logic                 frame_last;
		coord_t               tile_y;
		coord_t               tile_x;
		logic [FEATURE_W-1:0] value;
	} tile_feature_t;

	// Colour patterns that a tile column of a generated frame is filled with.
	typedef enum int {
		SHADE_BLACK,
		SHADE_WHITE,
		SHADE_PRIMARY,
		SHADE_NEAR_WHITE,
		SHADE_NOISE
	} shade_t;

	// How the receiver paces m_tready when no long hold-off is running.
	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_COMB,
		READY_LAZY
	} ready_mode_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIXEL_W-1:0]    s_tdata  = '0;
	logic [0:0]            s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	// Predicted state of the block: raster position and one running sum per
	// tile column.
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned tile_acc [OUT_WIDTH];

	// Features that the block still owes, oldest first.
	tile_feature_t pending_features [$];

	int     mismatch_count     = 0;
	int     pixels_sent        = 0;
	int     burst_left         = 0;
	int     burst_cap          = 16;
	int     gap_cap            = 6;
	int     hold_request       = 0;
	shade_t column_shade [OUT_WIDTH];

	rgb565_crop_gray_block_average dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Gray level of one RGB565 word: each channel is widened to eight bits by
	// repeating its top bits, then weighted 5:9:2 and divided by sixteen.
	function automatic int unsigned gray_level(input logic [PIXEL_W-1:0] px);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		r = 32'({px[15:11], px[15:13]});
		g = 32'({px[10:5], px[10:9]});
		b = 32'({px[4:0], px[4:2]});
		return (5 * r + 9 * g + 2 * b) >> 4;
	endfunction

	// Moves the predicted state on by one accepted pixel. A pixel that closes
	// a tile (its bottom-right corner) queues the feature that must follow.
	task automatic accumulate_pixel(input logic [PIXEL_W-1:0] px, input logic start);
		int            rel_x;
		int            rel_y;
		int            tx;
		int            ty;
		int            dx;
		int            dy;
		tile_feature_t feat;
		if (start) begin
			col_pos = 0;
			row_pos = 0;
		end
		rel_x = int'(col_pos) - CROP_X0;
		rel_y = int'(row_pos) - CROP_Y0;
		if (rel_x >= 0 && rel_x < OUT_WIDTH * BLOCK && rel_y >= 0 && rel_y < OUT_HEIGHT * BLOCK) begin
			tx = rel_x / BLOCK;
			dx = rel_x % BLOCK;
			ty = rel_y / BLOCK;
			dy = rel_y % BLOCK;
			// The top-left pixel of a tile loads the sum, so stale sums from a
			// frame that stopped early can never leak into a new tile.
			if (dx == 0 && dy == 0) begin
				tile_acc[tx] = gray_level(px);
			end else begin
				tile_acc[tx] += gray_level(px);
			end
			if (dx == BLOCK - 1 && dy == BLOCK - 1) begin
				feat.value = FEATURE_W'((longint'(tile_acc[tx]) * 32768) /
					longint'(BLOCK * BLOCK * 255));
				feat.tile_x = coord_t'(tx);
				feat.tile_y = coord_t'(ty);
				feat.frame_last = (tx == OUT_WIDTH - 1 && ty == OUT_HEIGHT - 1);
				pending_features.push_back(feat);
			end
		end
		// Without a frame start the position simply runs on, wrapping the row
		// at the frame height as though a fresh frame had begun.
		col_pos++;
		if (col_pos >= FRAME_WIDTH) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= FRAME_HEIGHT) begin
				row_pos = 0;
			end
		end
	endtask

	function automatic void flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endfunction

	// Offers one pixel and returns at the edge that accepts it. The sender
	// works in bursts; between bursts tvalid may drop for a random gap. Within a
	// burst tvalid stays high from one transaction to the next.
	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic start);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, burst_cap);
			gap = (gap_cap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_cap);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		pixels_sent++;
		accumulate_pixel(px, start);
	endtask

	// Lowers tvalid once the last transaction has gone, and waits for a clock
	// edge so that no later assignment can fall in the same time step.
	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [PIXEL_W-1:0] pick_pixel(input shade_t shade);
		logic [PIXEL_W-1:0] px;
		case (shade)
			SHADE_BLACK: begin
				px = 16'h0000;
			end
			SHADE_WHITE: begin
				px = 16'hFFFF;
			end
			SHADE_PRIMARY: begin
				case ($urandom_range(0, 2))
					0:       px = 16'hF800;
					1:       px = 16'h07E0;
					default: px = 16'h001F;
				endcase
			end
			SHADE_NEAR_WHITE: begin
				// One bit short of full white lands the feature just under 1.0.
				px = 16'hFFFF ^ (16'h0001 << $urandom_range(0, 15));
			end
			default: begin
				px = PIXEL_W'($urandom);
			end
		endcase
		return px;
	endfunction

	function automatic void choose_shades(input bit all_noise);
		for (int i = 0; i < OUT_WIDTH; i++) begin
			column_shade[i] = all_noise ? SHADE_NOISE : shade_t'($urandom_range(0, 4));
		end
	endfunction

	// Sends a run of raster pixels, filling each tile column with its chosen
	// shade and everything outside the crop with noise.
	task automatic send_run(input int count, input logic with_start);
		int          i;
		int          col;
		int          rel;
		logic        start;
		shade_t      shade;
		for (i = 0; i < count; i++) begin
			start = with_start && i == 0;
			col = start ? 0 : int'(col_pos);
			rel = col - CROP_X0;
			shade = (rel >= 0 && rel < OUT_WIDTH * BLOCK) ? column_shade[rel / BLOCK] : SHADE_NOISE;
			send_pixel(pick_pixel(shade), start);
		end
	endtask

	// Hand-picked pixels: the first transaction after reset carries no frame
	// start, then frame starts arrive back to back, on every colour extreme,
	// and again part way along a row.
	task automatic test_restart_corners();
		int i;
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'hF800, 1'b0);
		send_pixel(16'h07E0, 1'b0);
		send_pixel(16'h001F, 1'b0);
		send_pixel(16'h07FF, 1'b1);
		send_pixel(16'hF81F, 1'b0);
		send_pixel(16'hFFE0, 1'b0);
		send_pixel(16'h8410, 1'b0);
		send_pixel(16'h7BEF, 1'b0);
		send_pixel(16'h0821, 1'b0);
		send_pixel(16'hAAAA, 1'b0);
		send_pixel(16'h5555, 1'b0);
		for (i = 0; i < 9; i++) begin
			send_pixel(PIXEL_W'($urandom), i % 3 == 2);
		end
	endtask

	// Short frame openings that reach into the crop and start tiles, mixed
	// with noise that restarts frames at random places, so that tiles are
	// begun and then cut short before any of them closes.
	task automatic test_tile_frames();
		int first_pixel;
		int i;
		int n;
		first_pixel = pixels_sent;
		while (pixels_sent - first_pixel < 120) begin
			case ($urandom_range(0, 2))
				0: begin
					n = $urandom_range(1, 40);
					for (i = 0; i < n; i++) begin
						send_pixel(PIXEL_W'($urandom), $urandom_range(0, 19) == 0);
					end
				end
				default: begin
					choose_shades($urandom_range(0, 3) == 0);
					send_run($urandom_range(1, 60), 1'b1);
				end
			endcase
		end
	endtask

	// A fresh frame runs down to the first tile row, whose first tiles close
	// under the usual pacing. Part way along the row the receiver holds off
	// for a long stretch while the sender streams with no gaps, so finished
	// features back up and the input has to stall.
	task automatic test_output_stall();
		choose_shades(1'b0);
		send_run((BLOCK - 1) * FRAME_WIDTH + CROP_X0 + 12 * BLOCK, 1'b1);
		burst_cap = 4096;
		gap_cap = 0;
		burst_left = 0;
		hold_request = 400;
		send_run(CROP_X1 - CROP_X0 - 12 * BLOCK, 1'b0);
	endtask

	// Receiver: switches between pacing modes at random, including long
	// stretches of steady readiness, and honours a requested hold-off that it
	// counts down in cycles itself.
	initial begin : receiver
		int          hold_left;
		int          stall_left;
		int          mode_left;
		int          phase;
		ready_mode_t mode;
		hold_left = 0;
		stall_left = 0;
		mode_left = 0;
		phase = 0;
		mode = READY_ALWAYS;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left <= 0) begin
				mode = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(256, 1024);
			end
			mode_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					READY_ALWAYS: begin
						m_tready <= 1'b1;
					end
					READY_COIN: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					READY_COMB: begin
						m_tready <= (phase % 7) < 4;
					end
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							m_tready <= 1'b0;
						end else if ($urandom_range(0, 9) == 0) begin
							stall_left = $urandom_range(1, 12);
							m_tready <= 1'b0;
						end else begin
							m_tready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Every master transaction is matched against the oldest owed feature,
	// field by field, padding bits included.
	always @(posedge clk) begin : feature_check
		tile_feature_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_features.size() == 0) begin
				flag_error($sformatf("feature with none expected: tdata=%h tlast=%b",
					m_tdata, m_tlast));
			end else begin
				want = pending_features.pop_front();
				if (m_tdata[FEATURE_W-1:0] !== want.value ||
				    m_tdata[FEATURE_W +: COORD_W] !== want.tile_x ||
				    m_tdata[FEATURE_W + COORD_W +: COORD_W] !== want.tile_y ||
				    m_tdata[OUT_DATA_W-1:FEATURE_W + 2 * COORD_W] !== '0 ||
				    m_tlast !== want.frame_last) begin
					flag_error($sformatf({"feature mismatch: expected value=%0d x=%0d y=%0d ",
						"last=%b, got value=%0d x=%0d y=%0d pad=%h last=%b"},
						want.value, want.tile_x, want.tile_y, want.frame_last,
						m_tdata[FEATURE_W-1:0], m_tdata[FEATURE_W +: COORD_W],
						m_tdata[FEATURE_W + COORD_W +: COORD_W],
						m_tdata[OUT_DATA_W-1:FEATURE_W + 2 * COORD_W], m_tlast));
				end
			end
		end
	end

	initial begin : run
		int waited;
		for (int i = 0; i < OUT_WIDTH; i++) begin
			tile_acc[i] = 0;
		end
		col_pos = 0;
		row_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_restart_corners();
		test_tile_frames();
		test_output_stall();
		stop_sending();

		// Let the owed features drain, then keep watching in case the block
		// sends something it should not.
		waited = 0;
		while (pending_features.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_features.size() != 0) begin
			flag_error($sformatf("%0d features never arrived", pending_features.size()));
		end

		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: the slowest correct run needs well under a tenth of this.
	initial begin : watchdog
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
